### src/msp_frame_parser_defines.svh
// Assertion helpers used by the frame parser datapath.
`ifndef MSP_FRAME_PARSER_DEFINES_SVH
`define MSP_FRAME_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msp_frame_parser: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msp_frame_parser: assertion failed");

`endif

### src/msp_pkg.sv
`default_nettype none

package msp_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_M      = 8'h4D;
  localparam logic [7:0] CHAR_LT     = 8'h3C;

  typedef enum logic [1:0] {
    KIND_OTHER   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_t;

  typedef struct packed {
    logic cap_size;
    logic cap_cmd;
    logic store_byte;
    logic load_pass;
    logic load_empty;
    logic emit_start;
    logic emit_rd;
    logic load_payload;
  } cmd_t;

  typedef struct packed {
    logic is_dollar;
    logic is_m;
    logic is_lt;
    logic size_ok;
    logic fill_lt_len;
    logic csum_ok;
    logic len_zero;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### src/msp_ctrl.sv
`default_nettype none

module msp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire msp_pkg::status_t status,
  output msp_pkg::cmd_t        cmd
);
  import msp_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_DOLLAR  = 8'b0000_0010,
    ST_M       = 8'b0000_0100,
    ST_ARROW   = 8'b0000_1000,
    ST_SIZE    = 8'b0001_0000,
    ST_CMD     = 8'b0010_0000,
    ST_EMIT_RD = 8'b0100_0000,
    ST_EMIT_WR = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   parsing;
  logic   in_fire;

  assign parsing   = (state_r != ST_EMIT_RD) && (state_r != ST_EMIT_WR);
  assign in_tready = parsing && status.out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (status.is_dollar) begin
            state_nxt = ST_DOLLAR;
          end else begin
            cmd.load_pass = 1'b1;
          end
        end
      end
      ST_DOLLAR: begin
        if (in_fire) begin
          state_nxt = status.is_m ? ST_M : ST_IDLE;
        end
      end
      ST_M: begin
        if (in_fire) begin
          state_nxt = status.is_lt ? ST_ARROW : ST_IDLE;
        end
      end
      ST_ARROW: begin
        if (in_fire) begin
          if (status.size_ok) begin
            cmd.cap_size = 1'b1;
            state_nxt    = ST_SIZE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SIZE: begin
        if (in_fire) begin
          cmd.cap_cmd = 1'b1;
          state_nxt   = ST_CMD;
        end
      end
      ST_CMD: begin
        if (in_fire) begin
          priority if (status.fill_lt_len) begin
            cmd.store_byte = 1'b1;
          end else if (status.csum_ok && status.len_zero) begin
            cmd.load_empty = 1'b1;
            state_nxt      = ST_IDLE;
          end else if (status.csum_ok) begin
            cmd.emit_start = 1'b1;
            state_nxt      = ST_EMIT_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (status.out_free) begin
          cmd.load_payload = 1'b1;
          state_nxt        = status.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### src/msp_datapath.sv
`default_nettype none

`include "msp_frame_parser_defines.svh"

module msp_datapath #(
  parameter int BUF_DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [7:0]       in_byte,
  input  wire msp_pkg::cmd_t    cmd,
  output msp_pkg::status_t      status,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [31:0]           out_tdata,
  output logic                  out_tlast,
  output logic [1:0]            out_tuser
);
  import msp_pkg::*;

  localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic [7:0] payload_mem [BUF_DEPTH];
  logic [7:0] rd_data_r;

  logic [6:0] declared_len_r, declared_len_nxt;
  logic [6:0] fill_count_r, fill_count_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;
  logic [7:0] frame_command_r, frame_command_nxt;
  logic [5:0] emit_idx_r, emit_idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  kind_t      out_kind_r, out_kind_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic [7:0] out_cmd_r, out_cmd_nxt;
  logic [6:0] out_len_r, out_len_nxt;
  logic [5:0] out_idx_r, out_idx_nxt;
  logic       out_last_r, out_last_nxt;

  logic       out_load;

  assign status.is_dollar   = (in_byte == CHAR_DOLLAR);
  assign status.is_m        = (in_byte == CHAR_M);
  assign status.is_lt       = (in_byte == CHAR_LT);
  assign status.size_ok     = (in_byte <= 8'(BUF_DEPTH));
  assign status.fill_lt_len = (fill_count_r < declared_len_r);
  assign status.csum_ok     = (running_xor_r == in_byte);
  assign status.len_zero    = (declared_len_r == 7'd0);
  assign status.emit_last   = (({1'b0, emit_idx_r} + 7'd1) == declared_len_r);
  assign status.out_free    = !out_valid_r || out_tready;

  assign out_load = cmd.load_pass || cmd.load_empty || cmd.load_payload;

  always_comb begin
    declared_len_nxt  = declared_len_r;
    fill_count_nxt    = fill_count_r;
    running_xor_nxt   = running_xor_r;
    frame_command_nxt = frame_command_r;
    emit_idx_nxt      = emit_idx_r;
    if (cmd.cap_size) begin
      declared_len_nxt = 7'(in_byte);
      fill_count_nxt   = 7'd0;
      running_xor_nxt  = in_byte;
    end
    if (cmd.cap_cmd) begin
      frame_command_nxt = in_byte;
      running_xor_nxt   = running_xor_r ^ in_byte;
    end
    if (cmd.store_byte) begin
      running_xor_nxt = running_xor_r ^ in_byte;
      fill_count_nxt  = fill_count_r + 7'd1;
    end
    if (cmd.emit_start) begin
      emit_idx_nxt = 6'd0;
    end
    if (cmd.load_payload) begin
      emit_idx_nxt = emit_idx_r + 6'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_cmd_nxt   = out_cmd_r;
    out_len_nxt   = out_len_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    priority if (cmd.load_pass) begin
      out_kind_nxt = KIND_OTHER;
      out_data_nxt = in_byte;
      out_cmd_nxt  = 8'd0;
      out_len_nxt  = 7'd0;
      out_idx_nxt  = 6'd0;
      out_last_nxt = 1'b1;
    end else if (cmd.load_empty) begin
      out_kind_nxt = KIND_EMPTY;
      out_data_nxt = 8'd0;
      out_cmd_nxt  = frame_command_r;
      out_len_nxt  = 7'd0;
      out_idx_nxt  = 6'd0;
      out_last_nxt = 1'b1;
    end else if (cmd.load_payload) begin
      out_kind_nxt = KIND_PAYLOAD;
      out_data_nxt = rd_data_r;
      out_cmd_nxt  = frame_command_r;
      out_len_nxt  = declared_len_r;
      out_idx_nxt  = emit_idx_r;
      out_last_nxt = status.emit_last;
    end else begin
      out_kind_nxt = out_kind_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      payload_mem[fill_count_r[ADDR_W-1:0]] <= in_byte;
    end
    if (cmd.emit_rd) begin
      rd_data_r <= payload_mem[emit_idx_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      declared_len_r  <= 7'd0;
      fill_count_r    <= 7'd0;
      running_xor_r   <= 8'd0;
      frame_command_r <= 8'd0;
      emit_idx_r      <= 6'd0;
      out_valid_r     <= 1'b0;
    end else begin
      declared_len_r  <= declared_len_nxt;
      fill_count_r    <= fill_count_nxt;
      running_xor_r   <= running_xor_nxt;
      frame_command_r <= frame_command_nxt;
      emit_idx_r      <= emit_idx_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_len_r  <= out_len_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_idx_r, out_len_r, out_cmd_r, out_data_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;

  `MSP_ASSERT_SAME(a_load_into_free_slot, clk, rst_n, out_load, status.out_free)
  `MSP_ASSERT_SAME(a_store_within_frame, clk, rst_n, cmd.store_byte,
                   fill_count_r < declared_len_r)
  `MSP_ASSERT_SAME(a_emit_within_frame, clk, rst_n, cmd.load_payload,
                   ({1'b0, emit_idx_r} < declared_len_r))
  `MSP_ASSERT_NEXT(a_len_fits_buffer, clk, rst_n, cmd.cap_size,
                   declared_len_r <= 7'(BUF_DEPTH))

endmodule

`default_nettype wire

### src/msp_frame_parser.sv
`default_nettype none

// Request frame parser for a serial control protocol: each input transfer carries one
// received byte. Frames of the form '$' 'M' '<' size command payload checksum are
// recognised; a matching XOR checksum over size, command and payload releases the
// payload as one output transfer per byte (tlast on the final byte), or a single
// empty-frame transfer when the size is zero. Bad checksums and sizes above BUF_DEPTH
// drop the frame silently, and bytes seen while idle that are not '$' pass straight
// out as other data. While a frame is being parsed one byte is taken every cycle as
// long as the output register is free or being emptied. While a valid frame is emitted,
// each payload byte goes through the registered read of the payload buffer followed by
// the load of the output register, and no input is taken during that time.
module msp_frame_parser #(
  parameter int BUF_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // data_byte, command, payload_len, byte_index, zero fill
  output logic             out_tlast,
  output logic [1:0]       out_tuser   // kind
);
  import msp_pkg::*;

  cmd_t    cmd;
  status_t status;

  msp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  msp_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
